// ----- rtl/ezr_pkg.sv -----
// Shared constants, types and functions for the Euler rotation pipeline.
package ezr_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int QW = 64;                       // Q60 CORDIC word width
    localparam int FULL_TURN = 23592960;
    localparam int QUARTER_TURN = 5898240;
    localparam logic [37:0] PI_Q36 = 38'h3243F6A888;
    localparam logic signed [63:0] QUARTER_PI_Q60 = 64'sh0C90FDAA22168C23;
    localparam logic signed [63:0] INV_GAIN_Q60 = 64'sd700114967507363257;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
    localparam logic signed [66:0] HALF_Q30 = 67'sd536870912;

    // 92 full turns of whole degrees: keeps the whole-degree part positive
    localparam logic signed [16:0] DEG_OFFSET = 17'sd33120;
    // ceil(2^26 / 360): exact quotient for any 17-bit dividend
    localparam logic [17:0] RECIP_360 = 18'(((27'd1 << 26) + 27'd359) / 27'd360);
    // pi * 256 / 180 = pi * 64 / 45, split as 45 * RAD_A + RAD_B over 45
    localparam logic [43:0] PI_X64 = 44'(PI_Q36) << 6;
    localparam logic [38:0] RAD_A = 39'(PI_X64 / 44'd45);
    localparam logic [5:0]  RAD_B = 6'(PI_X64 % 44'd45);
    // ceil(2^35 / 45): exact quotient for any 29-bit dividend
    localparam logic [29:0] RECIP_45 = 30'(((36'd1 << 35) + 36'd44) / 36'd45);

    typedef logic signed [31:0] q30_t;

    // Angle after reduction: quadrant, zero flag, Q60 radians of the residual.
    typedef struct packed {
        logic [1:0]           quad;
        logic                 zero;
        logic signed [63:0]   z;
    } ang_t;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
    } cvec_t;

    // atan(2^-i) in Q60 by the truncated series; evaluated at elaboration.
    function automatic logic signed [63:0] step_angle(input int i);
        logic signed [63:0] sum;
        int e;
        sum = 64'sd0;
        if (i == 0)
            return QUARTER_PI_Q60;
        for (int k = 0; k < 61; k++)
        begin
            e = 60 - i * (2 * k + 1);
            if (e >= 0)
            begin
                if (k % 2 == 1)
                    sum = sum - 64'(signed'((64'd1 << e) / 64'(2 * k + 1)));
                else
                    sum = sum + 64'(signed'((64'd1 << e) / 64'(2 * k + 1)));
            end
        end
        return sum;
    endfunction

    function automatic logic signed [33:0] clamp34(input logic signed [33:0] v);
        if (v > ONE_Q30)
            return ONE_Q30;
        if (v < -ONE_Q30)
            return -ONE_Q30;
        return v;
    endfunction

    // Q60 -> Q30 with rounding and clamp.
    function automatic q30_t q60_to_q30(input logic signed [63:0] v);
        logic signed [64:0] t;
        logic signed [34:0] s;
        t = 65'(v) + 65'sd536870912;
        s = 35'(t >>> 30);
        if (s > 35'sd1073741824)
            return 32'sd1073741824;
        if (s < -35'sd1073741824)
            return -32'sd1073741824;
        return 32'(s);
    endfunction

    // (a*b + 2^29) >>> 30 on Q2.30 operands in [-1, 1].
    function automatic logic signed [33:0] qmul(input q30_t a, input q30_t b);
        logic signed [66:0] p;
        p = 67'(a) * 67'(b) + HALF_Q30;
        return 34'(p >>> 30);
    endfunction

endpackage

// ----- rtl/euler_zxz_rotation_and_flags.sv -----
// Top level of the Z-X-Z Euler rotation builder with translation flags.
//
// Input channel: in_valid/in_stall with translation shift_x/y/z (Q18.30) and
// angles angle_phi/theta/psi (Q16.16 degrees). An item is taken when in_valid
// is high and in_stall low. Output channel: out_valid/out_stall with the nine
// Q2.30 matrix entries and flags moves, turns, is_identity.
// Configuration: cfg_valid/cfg_ready write the 31-bit tolerance (reset 1);
// cfg_ready is always high; write only while the pipeline is empty.
// One item enters every cycle while the output is not stalled. The stages do
// angle reduction, one CORDIC stage per step plus entry and fold, then the
// matrix products and flags. The whole pipe advances as one; when the
// receiver stalls with a valid result waiting, every stage holds and the
// input is stalled in the same cycle (in_stall follows out_stall whenever the
// output stage is full). Reset clears all valid bits and sets tolerance to 1.
module euler_zxz_rotation_and_flags
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [47:0]  shift_x,
    input  logic signed [47:0]  shift_y,
    input  logic signed [47:0]  shift_z,
    input  logic signed [31:0]  angle_phi,
    input  logic signed [31:0]  angle_theta,
    input  logic signed [31:0]  angle_psi,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [30:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  m00,
    output logic signed [31:0]  m01,
    output logic signed [31:0]  m02,
    output logic signed [31:0]  m10,
    output logic signed [31:0]  m11,
    output logic signed [31:0]  m12,
    output logic signed [31:0]  m20,
    output logic signed [31:0]  m21,
    output logic signed [31:0]  m22,
    output logic                moves,
    output logic                turns,
    output logic                is_identity
);
    localparam int N = (ezr_pkg::CORDIC_STEPS > 60) ? 60 : ezr_pkg::CORDIC_STEPS;
    localparam int LAT = N + 8;

    logic [30:0]      tol_reg;
    logic [LAT-1:0]   vld_reg;
    logic             en;
    ezr_pkg::ang_t    a_phi, a_the, a_psi;
    ezr_pkg::q30_t    sphi, cphi, sthe, cthe, spsi, cpsi;
    ezr_pkg::q30_t    m [9];
    logic             mv_in;
    logic             mv_d_reg [N+5];

    assign en = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !en;
    assign cfg_ready = 1'b1;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= 31'd1;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
                tol_reg <= cfg_data;
            if (en)
                vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_comb
    begin
        mv_in = ((shift_x[47] ? -49'(shift_x) : 49'(shift_x)) > 49'(tol_reg))
             || ((shift_y[47] ? -49'(shift_y) : 49'(shift_y)) > 49'(tol_reg))
             || ((shift_z[47] ? -49'(shift_z) : 49'(shift_z)) > 49'(tol_reg));
    end

    // carry the translation flag alongside the angle path
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mv_d_reg[0] <= mv_in;
            for (int i = 1; i < N + 5; i++)
                mv_d_reg[i] <= mv_d_reg[i-1];
        end
    end

    ezr_reduce u_red_phi (.clk(clk), .en(en), .angle(angle_phi),   .ang(a_phi));
    ezr_reduce u_red_the (.clk(clk), .en(en), .angle(angle_theta), .ang(a_the));
    ezr_reduce u_red_psi (.clk(clk), .en(en), .angle(angle_psi),   .ang(a_psi));

    ezr_cordic u_cor_phi (.clk(clk), .en(en), .ang(a_phi), .s(sphi), .c(cphi));
    ezr_cordic u_cor_the (.clk(clk), .en(en), .ang(a_the), .s(sthe), .c(cthe));
    ezr_cordic u_cor_psi (.clk(clk), .en(en), .ang(a_psi), .s(spsi), .c(cpsi));

    ezr_matrix u_mat
    (
        .clk(clk), .en(en), .tol(tol_reg), .moves_in(mv_d_reg[N+4]),
        .sphi(sphi), .cphi(cphi), .sthe(sthe), .cthe(cthe), .spsi(spsi), .cpsi(cpsi),
        .m(m), .moves(moves), .turns(turns)
    );

    assign m00 = m[0];
    assign m01 = m[1];
    assign m02 = m[2];
    assign m10 = m[3];
    assign m11 = m[4];
    assign m12 = m[5];
    assign m20 = m[6];
    assign m21 = m[7];
    assign m22 = m[8];
    assign is_identity = !moves && !turns;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(m00) && $stable(turns))
        else $error("result changed while stalled");
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");
    a_ident: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_identity |-> m00 == 32'sd1073741824 && m22 == 32'sd1073741824)
        else $error("identity flagged on non-identity matrix");
endmodule

// ----- rtl/ezr_reduce.sv -----
// Angle reduction modulo 360 degrees and conversion of the residual to Q60 radians.
module ezr_reduce
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [31:0]   angle,
    output ezr_pkg::ang_t        ang
);
    // stage A: modulo on the whole degrees; stage B: quadrant split and scale by
    // pi*64/45 as a whole part and a remainder; stage C: remainder over 45, sum
    logic [24:0]        m_reg, m_next;
    logic [1:0]         quad_reg, quad_next;
    logic               zero_reg;
    logic [61:0]        ra_reg, ra_next;
    logic [28:0]        rb_reg, rb_next;
    logic [22:0]        r;
    logic signed [16:0] ipart;
    logic [16:0]        u;
    logic [34:0]        prod360;
    logic [16:0]        quo360;
    logic [8:0]         rem360;
    logic [58:0]        prod45;
    logic [63:0]        z_next;

    // the fraction bits pass through; only whole degrees need reducing
    always_comb
    begin
        ipart = 17'(angle >>> 16);
        u = ipart + ezr_pkg::DEG_OFFSET;
        prod360 = 35'(u) * 35'(ezr_pkg::RECIP_360);
        quo360 = 17'(prod360 >> 26);
        rem360 = 9'(u - quo360 * 17'd360);
        m_next = {rem360, angle[15:0]};
    end

    always_comb
    begin
        if (m_reg >= 25'(3 * ezr_pkg::QUARTER_TURN))
        begin
            quad_next = 2'd3;
            r = 23'(m_reg - 25'(3 * ezr_pkg::QUARTER_TURN));
        end
        else if (m_reg >= 25'(2 * ezr_pkg::QUARTER_TURN))
        begin
            quad_next = 2'd2;
            r = 23'(m_reg - 25'(2 * ezr_pkg::QUARTER_TURN));
        end
        else if (m_reg >= 25'(ezr_pkg::QUARTER_TURN))
        begin
            quad_next = 2'd1;
            r = 23'(m_reg - 25'(ezr_pkg::QUARTER_TURN));
        end
        else
        begin
            quad_next = 2'd0;
            r = 23'(m_reg);
        end
        ra_next = 62'(r) * 62'(ezr_pkg::RAD_A);
        rb_next = 29'(r) * 29'(ezr_pkg::RAD_B);
    end

    // floor(r*pi*64/45) = r*A + floor(r*B/45), the latter by reciprocal multiply
    always_comb
    begin
        prod45 = 59'(rb_reg) * 59'(ezr_pkg::RECIP_45);
        z_next = 64'(ra_reg) + 64'(prod45 >> 35);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg <= m_next;
            quad_reg <= quad_next;
            zero_reg <= (r == 23'd0);
            ra_reg <= ra_next;
            rb_reg <= rb_next;
            ang.quad <= quad_reg;
            ang.zero <= zero_reg;
            ang.z <= signed'(z_next);
        end
    end
endmodule

// ----- rtl/ezr_cordic.sv -----
// Pipelined rotation-mode CORDIC with quadrant fold to sine and cosine.
module ezr_cordic
(
    input  logic                 clk,
    input  logic                 en,
    input  ezr_pkg::ang_t        ang,
    output ezr_pkg::q30_t        s,
    output ezr_pkg::q30_t        c
);
    localparam int N = (ezr_pkg::CORDIC_STEPS > 60) ? 60 : ezr_pkg::CORDIC_STEPS;

    ezr_pkg::cvec_t  v_reg [N+1];
    logic [1:0]      quad_reg [N+1];
    logic            zero_reg [N+1];
    ezr_pkg::q30_t   sr, cr;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg[0].x <= ezr_pkg::INV_GAIN_Q60;
            v_reg[0].y <= 64'sd0;
            v_reg[0].z <= ang.z;
            quad_reg[0] <= ang.quad;
            zero_reg[0] <= ang.zero;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_step
        localparam logic signed [63:0] T = ezr_pkg::step_angle(i);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!v_reg[i].z[63])
                begin
                    v_reg[i+1].x <= v_reg[i].x - (v_reg[i].y >>> i);
                    v_reg[i+1].y <= v_reg[i].y + (v_reg[i].x >>> i);
                    v_reg[i+1].z <= v_reg[i].z - T;
                end
                else
                begin
                    v_reg[i+1].x <= v_reg[i].x + (v_reg[i].y >>> i);
                    v_reg[i+1].y <= v_reg[i].y - (v_reg[i].x >>> i);
                    v_reg[i+1].z <= v_reg[i].z + T;
                end
                quad_reg[i+1] <= quad_reg[i];
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    always_comb
    begin
        if (zero_reg[N])
        begin
            sr = 32'sd0;
            cr = 32'sd1073741824;
        end
        else
        begin
            sr = ezr_pkg::q60_to_q30(v_reg[N].y);
            cr = ezr_pkg::q60_to_q30(v_reg[N].x);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (quad_reg[N])
                2'd0:
                begin
                    s <= sr;
                    c <= cr;
                end
                2'd1:
                begin
                    s <= cr;
                    c <= -sr;
                end
                2'd2:
                begin
                    s <= -sr;
                    c <= -cr;
                end
                default:
                begin
                    s <= -cr;
                    c <= sr;
                end
            endcase
        end
    end
endmodule

// ----- rtl/ezr_matrix.sv -----
// Matrix products, clamping and flag evaluation.
module ezr_matrix
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [30:0]          tol,
    input  logic                 moves_in,
    input  ezr_pkg::q30_t        sphi,
    input  ezr_pkg::q30_t        cphi,
    input  ezr_pkg::q30_t        sthe,
    input  ezr_pkg::q30_t        cthe,
    input  ezr_pkg::q30_t        spsi,
    input  ezr_pkg::q30_t        cpsi,
    output ezr_pkg::q30_t        m [9],
    output logic                 moves,
    output logic                 turns
);
    // stage 1: first products
    ezr_pkg::q30_t tp_reg, tc_reg, spsi1_reg, cpsi1_reg;
    logic signed [33:0] p_cc_reg, p_sc_reg, p_cs_reg, p_ss_reg;
    logic signed [33:0] p_sthe_sphi_reg, p_sthe_cphi_reg, p_spsi_sthe_reg, p_cpsi_sthe_reg;
    ezr_pkg::q30_t cthe1_reg;
    logic mv1_reg, mv2_reg, mv3_reg;
    // stage 2: second products, entries
    ezr_pkg::q30_t m2_reg [9];
    logic [8:0] code;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tp_reg <= 32'(ezr_pkg::clamp34(ezr_pkg::qmul(cthe, sphi)));
            tc_reg <= 32'(ezr_pkg::clamp34(ezr_pkg::qmul(cthe, cphi)));
            spsi1_reg <= spsi;
            cpsi1_reg <= cpsi;
            p_cc_reg <= ezr_pkg::qmul(cpsi, cphi);
            p_sc_reg <= ezr_pkg::qmul(spsi, cphi);
            p_cs_reg <= ezr_pkg::qmul(cpsi, sphi);
            p_ss_reg <= ezr_pkg::qmul(spsi, sphi);
            p_sthe_sphi_reg <= ezr_pkg::qmul(sthe, sphi);
            p_sthe_cphi_reg <= ezr_pkg::qmul(sthe, cphi);
            p_spsi_sthe_reg <= ezr_pkg::qmul(spsi, sthe);
            p_cpsi_sthe_reg <= ezr_pkg::qmul(cpsi, sthe);
            cthe1_reg <= cthe;
            mv1_reg <= moves_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_reg[0] <= 32'(ezr_pkg::clamp34(p_cc_reg - ezr_pkg::qmul(tp_reg, spsi1_reg)));
            m2_reg[1] <= 32'(ezr_pkg::clamp34(-p_sc_reg - ezr_pkg::qmul(tp_reg, cpsi1_reg)));
            m2_reg[2] <= 32'(ezr_pkg::clamp34(p_sthe_sphi_reg));
            m2_reg[3] <= 32'(ezr_pkg::clamp34(p_cs_reg + ezr_pkg::qmul(tc_reg, spsi1_reg)));
            m2_reg[4] <= 32'(ezr_pkg::clamp34(-p_ss_reg + ezr_pkg::qmul(tc_reg, cpsi1_reg)));
            m2_reg[5] <= 32'(ezr_pkg::clamp34(-p_sthe_cphi_reg));
            m2_reg[6] <= 32'(ezr_pkg::clamp34(p_spsi_sthe_reg));
            m2_reg[7] <= 32'(ezr_pkg::clamp34(p_cpsi_sthe_reg));
            m2_reg[8] <= 32'(ezr_pkg::clamp34(34'(cthe1_reg)));
            mv2_reg <= mv1_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            code[i] = ((m2_reg[i][31] ? -33'(m2_reg[i]) : 33'(m2_reg[i])) > 33'(tol));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m <= m2_reg;
            mv3_reg <= mv2_reg;
            turns <= !(code == 9'h111 && m2_reg[0] == 32'sd1073741824
                       && m2_reg[4] == 32'sd1073741824 && m2_reg[8] == 32'sd1073741824);
        end
    end

    assign moves = mv3_reg;
endmodule
